// ===== src/mshi_pkg.sv =====
package mshi_pkg;

  localparam int MAX_SLOTS  = 32;
  localparam int MAX_SECOND = 32;

  localparam int DATA_W = 32;
  localparam int KIND_W = 2;

  localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(MAX_SLOTS + 1);
  localparam int SEC_AW  = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
  localparam int SEC_CW  = $clog2(MAX_SECOND + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_SLOT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GO     = 2'd2;

  typedef enum logic [1:0] {
    OP_SLOT,
    OP_SECOND,
    OP_GO
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic priming;
    logic merging;
  } back_status_t;

endpackage

// ===== src/mshi_if.sv =====
interface mshi_item_if;
  logic                              valid;
  logic                              ready;
  logic [mshi_pkg::KIND_W-1:0]       kind;
  logic signed [mshi_pkg::DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface mshi_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [mshi_pkg::DATA_W-1:0] merged_value;
  logic                              last;
  logic                              dropped;

  modport source (output valid, merged_value, last, dropped, input ready);
  modport sink (input valid, merged_value, last, dropped, output ready);
endinterface

// ===== src/mshi_front.sv =====
module mshi_front (
  input  logic            clk,
  input  logic            rst,
  mshi_item_if.sink       item,
  output logic            cmd_valid,
  output mshi_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);
  import mshi_pkg::*;

  cmd_t             queue [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             push;
  logic             known;
  cmd_t             cmd_in;

  assign item.ready = (count != (QAW+1)'(QUEUE_DEPTH));
  assign cmd_valid  = (count != '0);
  assign cmd        = queue[rd_ptr];

  // classify the word; unused kinds are taken and dropped here
  always_comb begin
    known        = 1'b1;
    cmd_in.value = item.value;
    case (item.kind)
      KIND_SLOT:   cmd_in.op = OP_SLOT;
      KIND_SECOND: cmd_in.op = OP_SECOND;
      KIND_GO:     cmd_in.op = OP_GO;
      default: begin
        cmd_in.op = OP_SLOT;
        known     = 1'b0;
      end
    endcase
  end

  assign push = item.valid && item.ready && known;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/mshi_back.sv =====
module mshi_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  mshi_pkg::cmd_t         cmd,
  output logic                   cmd_pop,
  output mshi_pkg::back_status_t status,
  mshi_result_if.source          result
);
  import mshi_pkg::*;

  logic signed [DATA_W-1:0] first_mem  [MAX_SLOTS];
  logic signed [DATA_W-1:0] second_mem [MAX_SECOND];

  state_t                   state;
  state_t                   state_next;
  logic [SLOT_CW-1:0]       slot_count;
  logic [SLOT_CW-1:0]       first_count;
  logic [SEC_CW-1:0]        second_count;
  logic                     overflow_seen;
  logic [SLOT_CW-1:0]       i;
  logic [SLOT_CW-1:0]       i_next;
  logic [SEC_CW-1:0]        j;
  logic [SEC_CW-1:0]        j_next;
  logic [SLOT_CW-1:0]       p;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     out_dropped;

  logic                     have_a;
  logic                     have_b;
  logic                     take_a;
  logic                     take_b;
  logic signed [DATA_W-1:0] val;
  logic                     final_slot;
  logic                     step;
  logic                     do_slot;
  logic                     do_second;
  logic                     do_go;
  logic                     slot_full;
  logic                     second_full;
  logic                     wr_a;
  logic                     wr_b;
  logic                     clear;

  assign slot_full   = (slot_count == SLOT_CW'(MAX_SLOTS));
  assign second_full = (second_count == SEC_CW'(MAX_SECOND));

  // rd_a and rd_b always hold the heads at i and j while merging
  assign have_a     = (i < first_count);
  assign have_b     = (j < second_count);
  assign take_a     = have_a && (!have_b || (rd_a < rd_b));
  assign take_b     = have_b && !take_a;
  assign val        = take_a ? rd_a : (take_b ? rd_b : '0);
  assign final_slot = (p + SLOT_CW'(1) == slot_count);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.op == OP_GO && slot_count != '0) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: state_next = ST_MERGE;
      ST_MERGE: begin
        if (step && final_slot) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    step      = 1'b0;
    do_slot   = 1'b0;
    do_second = 1'b0;
    do_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_pop   = cmd_valid;
        do_slot   = cmd_valid && cmd.op == OP_SLOT;
        do_second = cmd_valid && cmd.op == OP_SECOND;
        do_go     = cmd_valid && cmd.op == OP_GO;
      end
      ST_MERGE: step = !out_valid || result.ready;
      default: step = 1'b0;
    endcase
    wr_a  = do_slot && !slot_full && cmd.value != '0;
    wr_b  = do_second && !second_full;
    clear = (do_go && slot_count == '0) || (step && final_slot);
  end

  always_comb begin
    if (state != ST_MERGE || (step && final_slot)) begin
      i_next = '0;
      j_next = '0;
    end else begin
      i_next = (step && take_a) ? i + SLOT_CW'(1) : i;
      j_next = (step && take_b) ? j + SEC_CW'(1) : j;
    end
  end

  // registered read at the next index; in idle and prime that is entry zero
  always_ff @(posedge clk) begin
    if (wr_a) begin
      first_mem[first_count[SLOT_AW-1:0]] <= cmd.value;
    end
    rd_a <= first_mem[i_next[SLOT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      second_mem[second_count[SEC_AW-1:0]] <= cmd.value;
    end
    rd_b <= second_mem[j_next[SEC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_count    <= '0;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
      p             <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      if (clear) begin
        slot_count    <= '0;
        first_count   <= '0;
        second_count  <= '0;
        overflow_seen <= 1'b0;
        p             <= '0;
      end else begin
        if (do_slot) begin
          if (slot_full) begin
            overflow_seen <= 1'b1;
          end else begin
            slot_count <= slot_count + SLOT_CW'(1);
          end
        end
        if (wr_a) begin
          first_count <= first_count + SLOT_CW'(1);
        end
        if (do_second && second_full) begin
          overflow_seen <= 1'b1;
        end
        if (wr_b) begin
          second_count <= second_count + SEC_CW'(1);
        end
        if (step) begin
          p <= p + SLOT_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_value   <= val;
      out_last    <= final_slot;
      out_dropped <= overflow_seen;
    end
  end

  assign result.valid        = out_valid;
  assign result.merged_value = out_value;
  assign result.last         = out_last;
  assign result.dropped      = out_dropped;

  assign status.priming = (state == ST_PRIME);
  assign status.merging = (state == ST_MERGE);

endmodule

// ===== src/merge_sorted_into_holed_array.sv =====
// Merge of a holed slot array with a second sorted list.
//
// Channels: item (sink) carries kind and value; result (source) carries
// merged_value, last and dropped. Both use valid/ready; a word moves on a
// rising edge with both high.
// Send slot words (kind 0, zero marks an empty slot), then second-list words
// (kind 1), then a go word (kind 2). Kind 3 is accepted and discarded.
// Each slot, second-list or go word enters a four-word command queue; the
// back end takes one queue word per cycle while idle, so loads sustain one
// word per cycle. Go with n loaded slots: a prime state reads the list
// heads from the two memories, then n results follow at one per cycle while
// the output is not stalled, the last with last set. Go with no slots emits
// nothing. After go all counts and the drop flag clear.
// A result waits in the output register while ready is low; the merge halts
// but the queue keeps taking words until it is full.
// Reset (rst, synchronous) empties the queue and clears counts and flags;
// list memory contents are not cleared.
module merge_sorted_into_holed_array (
  input  logic          clk,
  input  logic          rst,
  mshi_item_if.sink     item,
  mshi_result_if.source result
);
  import mshi_pkg::*;

  logic         cmd_valid;
  cmd_t         cmd;
  logic         cmd_pop;
  back_status_t status;

  mshi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mshi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .status    (status),
    .result    (result)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready &&
     (item.kind == KIND_SLOT || item.kind == KIND_SECOND || item.kind == KIND_GO))
    |=> cmd_valid)
    else $error("accepted word missing from queue");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (status.merging || status.priming) |-> !cmd_pop)
    else $error("queue popped during merge");

  a_prime_once: assert property (@(posedge clk) disable iff (rst)
    status.priming |=> status.merging)
    else $error("prime not followed by merge");

endmodule

// ===== tb/sv/merge_sorted_into_holed_array_tb.sv =====
`timescale 1ns / 100ps

module merge_sorted_into_holed_array_tb;
  import mshi_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int DIRECTED_N = 25;
  localparam int RANDOM_WORDS = 310;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
    logic                     dropped;
  } merged_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [7:0]        reps;
    logic              typed;
    merged_word_t      merged;
  } stim_row_t;

  logic clk;
  logic rst;

  mshi_item_if   item_bus ();
  mshi_result_if result_bus ();

  merge_sorted_into_holed_array DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // merge state mirrored from the block
  logic signed [DATA_W-1:0] slot_vals   [MAX_SLOTS];
  logic signed [DATA_W-1:0] second_vals [MAX_SECOND];
  int unsigned slots_loaded;
  int unsigned firsts_held;
  int unsigned seconds_held;
  logic        drop_seen;

  merged_word_t merged_words_due [$];
  int  mismatch_count;
  bit  tx_calm;
  bit  rx_calm;
  int  random_words;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b0, '0},
    '{KIND_NONE,   32'hFFFF_FFFF, 8'd1, 1'b0, '0},
    '{KIND_NONE,   32'h0000_0000, 8'd1, 1'b0, '0},
    '{KIND_SLOT,   32'h8000_0000, 8'd1, 1'b0, '0},
    '{KIND_GO,     32'hFFFF_FFFF, 8'd1, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
    '{KIND_SLOT,   32'h7FFF_FFFF, 8'd1, 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
    '{KIND_SLOT,   32'h0000_0000, 8'd1, 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b1, '{32'sh0000_0000, 1'b1, 1'b0}},
    '{KIND_SLOT,   32'h0000_0000, 8'd1, 1'b0, '0},
    '{KIND_SECOND, 32'hFFFF_FFFF, 8'd1, 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b1, '{32'shFFFF_FFFF, 1'b1, 1'b0}},
    // second list only, no slots: go emits nothing but clears
    '{KIND_SECOND, 32'h5555_5555, 8'd1, 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b0, '0},
    // tie goes to the second list; second list out of order
    '{KIND_SLOT,   32'h0000_0005, 8'd1, 1'b0, '0},
    '{KIND_SLOT,   32'h0000_0000, 8'd1, 1'b0, '0},
    '{KIND_SECOND, 32'h0000_0005, 8'd1, 1'b0, '0},
    '{KIND_SECOND, 32'hAAAA_AAAA, 8'd1, 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b0, '0},
    // overfill both stores, lists together exceed the slots
    '{KIND_SLOT,   32'h0000_0001, 8'(MAX_SLOTS + 1), 1'b0, '0},
    '{KIND_SECOND, 32'h0000_0002, 8'(MAX_SECOND + 1), 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b0, '0},
    // lists run out: trailing zeros
    '{KIND_SECOND, 32'h0000_0007, 8'd1, 1'b0, '0},
    '{KIND_SLOT,   32'h0000_0000, 8'd3, 1'b0, '0},
    '{KIND_GO,     32'h0000_0000, 8'd1, 1'b0, '0}
  };

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic merge_step(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
    int unsigned i;
    int unsigned j;
    merged_word_t w;
    i = 0;
    j = 0;
    case (k)
      KIND_SLOT: begin
        if (slots_loaded >= MAX_SLOTS) begin
          drop_seen = 1'b1;
        end else begin
          slots_loaded++;
          if (v != 0) begin
            slot_vals[firsts_held] = v;
            firsts_held++;
          end
        end
      end
      KIND_SECOND: begin
        if (seconds_held >= MAX_SECOND) begin
          drop_seen = 1'b1;
        end else begin
          second_vals[seconds_held] = v;
          seconds_held++;
        end
      end
      KIND_GO: begin
        for (int unsigned p = 0; p < slots_loaded; p++) begin
          // second list wins ties
          if (i < firsts_held && (j >= seconds_held || slot_vals[i] < second_vals[j])) begin
            w.merged_value = slot_vals[i];
            i++;
          end else if (j < seconds_held) begin
            w.merged_value = second_vals[j];
            j++;
          end else begin
            w.merged_value = '0;
          end
          w.last = (p + 1 == slots_loaded);
          w.dropped = drop_seen;
          merged_words_due.push_back(w);
        end
        slots_loaded = 0;
        firsts_held = 0;
        seconds_held = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
                           input logic typed, input merged_word_t typed_word);
    int gap;
    int held;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.kind  <= k;
    item_bus.value <= v;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    held = merged_words_due.size();
    merge_step(k, v);
    if (typed) begin
      while (merged_words_due.size() > held) void'(merged_words_due.pop_back());
      merged_words_due.push_back(typed_word);
    end
    if (k != KIND_NONE) random_words++;
  endtask

  // hold the sender until every expected word is back
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (merged_words_due.size() != 0);
  endtask

  function automatic longint next_sorted(longint cur, bit wide);
    longint nxt;
    nxt = cur + (wide ? longint'($urandom_range(0, 32'h0FFF_FFFF))
                      : longint'($urandom_range(0, 3)));
    return (nxt > 64'sd2147483647) ? 64'sd2147483647 : nxt;
  endfunction

  // receiver: random stalls, check each accepted word
  initial begin
    int stall;
    merged_word_t want;
    result_bus.ready <= 1'b0;
    rx_calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      if (merged_words_due.size() == 0) begin
        report_mismatch($sformatf("word %0d with none expected", result_bus.merged_value));
      end else begin
        want = merged_words_due.pop_front();
        if (result_bus.merged_value !== want.merged_value)
          report_mismatch($sformatf("merged_value %0d, expected %0d",
                                    result_bus.merged_value, want.merged_value));
        if (result_bus.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", result_bus.last, want.last));
        if (result_bus.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %b, expected %b",
                                    result_bus.dropped, want.dropped));
      end
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    #2_000_000;
    $display("merge_sorted_into_holed_array_tb: errors");
    $finish;
  end

  initial begin
    int shape;
    int nslots;
    int nsec;
    bit wide_a;
    bit wide_b;
    bit scramble;
    longint cur_a;
    longint cur_b;
    mismatch_count = 0;
    slots_loaded = 0;
    firsts_held = 0;
    seconds_held = 0;
    drop_seen = 1'b0;
    tx_calm = 1'b0;
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.kind  <= KIND_SLOT;
    item_bus.value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps)
        send_word(directed_rows[r].kind, directed_rows[r].value,
                  directed_rows[r].typed, directed_rows[r].merged);
    end
    drain_results();

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        // noise: any kind, any value, job may be left open
        repeat ($urandom_range(1, 6))
          send_word(2'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
      end else begin
        if (shape == 1) begin
          nslots = $urandom_range(MAX_SLOTS - 2, MAX_SLOTS + 2);
          nsec = $urandom_range(0, MAX_SECOND + 2);
        end else begin
          nslots = $urandom_range(1, 8);
          nsec = $urandom_range(0, nslots + 2);
        end
        scramble = ($urandom_range(0, 7) == 0);
        wide_a = $urandom_range(0, 1);
        wide_b = $urandom_range(0, 1);
        cur_a = wide_a ? longint'($signed($urandom())) : longint'($urandom_range(0, 40)) - 20;
        cur_b = wide_b ? longint'($signed($urandom())) : longint'($urandom_range(0, 40)) - 20;
        for (int s = 0; s < nslots; s++) begin
          if ($urandom_range(0, 3) == 0) begin
            send_word(KIND_SLOT, '0, 1'b0, '0);
          end else if (scramble) begin
            send_word(KIND_SLOT, $urandom(), 1'b0, '0);
          end else begin
            send_word(KIND_SLOT, cur_a[DATA_W-1:0], 1'b0, '0);
            cur_a = next_sorted(cur_a, wide_a);
          end
        end
        for (int s = 0; s < nsec; s++) begin
          if (scramble) begin
            send_word(KIND_SECOND, $urandom(), 1'b0, '0);
          end else begin
            send_word(KIND_SECOND, cur_b[DATA_W-1:0], 1'b0, '0);
            cur_b = next_sorted(cur_b, wide_b);
          end
        end
        send_word(KIND_GO, $urandom(), 1'b0, '0);
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("merge_sorted_into_holed_array_tb: clean");
    end else begin
      $display("merge_sorted_into_holed_array_tb: errors");
    end
    $finish;
  end

endmodule
